// ----- rtl/emcl_pkg.sv -----
// Shared types, codes and reset tables for the engine map cell logger.
package emcl_pkg;

  localparam int unsigned IDX_W = 4;
  localparam int unsigned VAL_W = 16;

  typedef enum logic [2:0] {
    CMD_LOAD_ROW = 3'd0,
    CMD_LOAD_COL = 3'd1,
    CMD_PEAK     = 3'd2,
    CMD_AVG      = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_PEAK,
    OP_AVG,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic [2:0]              command;
    logic [7:0]              throttle;
    logic [15:0]             engine_speed;
    logic signed [VAL_W-1:0] sample;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        column_index;
    logic [7:0]              breakpoint;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic [IDX_W-1:0]        row_found;
    logic [IDX_W-1:0]        column_found;
    logic signed [VAL_W-1:0] cell_value;
    logic                    cell_valid;
  } out_t;

  // work handed from the front to the back through the queue
  typedef struct packed {
    op_e                     op;
    logic                    hit;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] sample;
  } job_t;

  function automatic logic [7:0] def_row_brk(input int i);
    logic [7:0] v;
    case (i)
      0:       v = 8'd0;
      1:       v = 8'd4;
      2:       v = 8'd8;
      3:       v = 8'd15;
      4:       v = 8'd20;
      5:       v = 8'd27;
      6:       v = 8'd35;
      7:       v = 8'd50;
      8:       v = 8'd70;
      9:       v = 8'd85;
      default: v = 8'd100;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] def_col_brk(input int i);
    logic [7:0] v;
    case (i)
      0:       v = 8'd0;
      1:       v = 8'd20;
      2:       v = 8'd40;
      3:       v = 8'd55;
      4:       v = 8'd70;
      5:       v = 8'd80;
      6:       v = 8'd90;
      7:       v = 8'd100;
      8:       v = 8'd110;
      9:       v = 8'd120;
      10:      v = 8'd130;
      11:      v = 8'd140;
      12:      v = 8'd150;
      13:      v = 8'd160;
      14:      v = 8'd165;
      default: v = 8'd180;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/emcl_front.sv -----
// Front end: takes commands, holds breakpoints, finds the cell, issues jobs.
module emcl_front import emcl_pkg::*; #(
  parameter int unsigned ROWS    = 11,
  parameter int unsigned COLUMNS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  item_i,
  input  logic single_row_i,
  input  logic full_i,
  output logic busy_o,
  output logic push_o,
  output job_t job_o
);

  localparam int unsigned RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  in_t        stage_q;
  logic       stage_vld_q, stage_vld_d;
  logic [7:0] row_brk_q [ROWS];
  logic [7:0] col_brk_q [COLUMNS];

  logic [15:0]      col_bnd [COLUMNS];
  logic             row_hit, col_hit;
  logic [IDX_W-1:0] row_sel, col_sel;
  logic             row_in, col_in;
  logic             row_we, col_we;

  assign busy_o = stage_vld_q;
  assign push_o = stage_vld_q && !full_i;

  assign row_in = ({1'b0, stage_q.row_index} < (IDX_W + 1)'(ROWS));
  assign col_in = ({1'b0, stage_q.column_index} < (IDX_W + 1)'(COLUMNS));

  // row search: last breakpoint catches everything above it
  always_comb begin
    row_hit = 1'b0;
    row_sel = '0;
    if (single_row_i) begin
      row_hit = 1'b1;
    end else if (stage_q.throttle >= row_brk_q[ROWS-1]) begin
      row_hit = 1'b1;
      row_sel = IDX_W'(ROWS - 1);
    end else begin
      for (int i = ROWS - 2; i >= 0; i--) begin
        if (stage_q.throttle >= row_brk_q[i] && stage_q.throttle <= row_brk_q[i+1]) begin
          row_hit = 1'b1;
          row_sel = IDX_W'(i);
        end
      end
    end
  end

  // column breakpoints are in hundreds of rpm
  always_comb begin
    for (int i = 0; i < COLUMNS; i++) begin
      col_bnd[i] = {8'h00, col_brk_q[i]} * 16'd100;
    end
    col_hit = 1'b0;
    col_sel = '0;
    if (stage_q.engine_speed >= col_bnd[COLUMNS-1]) begin
      col_hit = 1'b1;
      col_sel = IDX_W'(COLUMNS - 1);
    end else begin
      for (int i = COLUMNS - 2; i >= 0; i--) begin
        if (stage_q.engine_speed >= col_bnd[i] && stage_q.engine_speed <= col_bnd[i+1]) begin
          col_hit = 1'b1;
          col_sel = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    job_o        = '0;
    job_o.op     = OP_PASS;
    job_o.sample = stage_q.sample;
    row_we       = 1'b0;
    col_we       = 1'b0;
    case (cmd_e'(stage_q.command))
      CMD_LOAD_ROW: begin
        job_o.row = stage_q.row_index;
        job_o.col = stage_q.column_index;
        job_o.hit = row_in;
        row_we    = row_in && !single_row_i;
      end
      CMD_LOAD_COL: begin
        job_o.row = stage_q.row_index;
        job_o.col = stage_q.column_index;
        job_o.hit = col_in;
        col_we    = col_in;
      end
      CMD_PEAK, CMD_AVG: begin
        if (row_hit && col_hit) begin
          job_o.op  = (cmd_e'(stage_q.command) == CMD_PEAK) ? OP_PEAK : OP_AVG;
          job_o.hit = 1'b1;
          job_o.row = row_sel;
          job_o.col = col_sel;
        end
      end
      CMD_CLEAR, CMD_READ: begin
        job_o.row = stage_q.row_index;
        job_o.col = stage_q.column_index;
        if (row_in && col_in) begin
          job_o.op  = (cmd_e'(stage_q.command) == CMD_CLEAR) ? OP_CLEAR : OP_READ;
          job_o.hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stage_vld_d = stage_vld_q;
    if (push_o) begin
      stage_vld_d = 1'b0;
    end
    if (start_i && !stage_vld_q) begin
      stage_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !stage_vld_q) begin
      stage_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        row_brk_q[i] <= def_row_brk(i);
      end
      for (int i = 0; i < COLUMNS; i++) begin
        col_brk_q[i] <= def_col_brk(i);
      end
    end else begin
      stage_vld_q <= stage_vld_d;
      if (push_o && row_we) begin
        row_brk_q[stage_q.row_index[RIW-1:0]] <= stage_q.breakpoint;
      end
      if (push_o && col_we) begin
        col_brk_q[stage_q.column_index[CIW-1:0]] <= stage_q.breakpoint;
      end
    end
  end

endmodule

// ----- rtl/emcl_fifo.sv -----
// Two-entry job queue between the front and the back.
module emcl_fifo import emcl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("job queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))
    else $error("job queue count out of step");
`endif

endmodule

// ----- rtl/emcl_back.sv -----
// Back end: cell memory, fill flags and the read-modify-write of each job.
module emcl_back import emcl_pkg::*; #(
  parameter int unsigned ROWS    = 11,
  parameter int unsigned COLUMNS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t head_i,
  input  logic empty_i,
  output logic pop_o,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    return AW'(int'(r) * COLUMNS + int'(c));
  endfunction

  bk_state_e               state_q, state_d;
  job_t                    job_q;
  logic signed [VAL_W-1:0] cell_mem [CELLS];
  logic signed [VAL_W-1:0] rd_q;
  logic [CELLS-1:0]        filled_q;
  out_t                    result_q, result_d;
  logic                    done_q, done_d;

  logic [AW-1:0]           rd_addr, ex_addr;
  logic                    old_ok;
  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W-1:0] new_val;
  logic                    mem_we, fill_set, fill_clr;

  assign rd_addr  = cell_addr(head_i.row, head_i.col);
  assign ex_addr  = cell_addr(job_q.row, job_q.col);
  assign old_ok   = filled_q[ex_addr];
  assign sum      = {rd_q[VAL_W-1], rd_q} + {job_q.sample[VAL_W-1], job_q.sample};
  assign done_o   = done_q;
  assign result_o = result_q;

  // empty cell takes the sample as is; average rounds toward minus infinity
  always_comb begin
    new_val = job_q.sample;
    if (old_ok) begin
      if (job_q.op == OP_PEAK) begin
        new_val = (rd_q > job_q.sample) ? rd_q : job_q.sample;
      end else begin
        new_val = sum[VAL_W:1];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    done_d   = 1'b0;
    result_d = result_q;
    mem_we   = 1'b0;
    fill_set = 1'b0;
    fill_clr = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.op == OP_PASS) begin
            done_d                = 1'b1;
            result_d.hit          = head_i.hit;
            result_d.row_found    = head_i.row;
            result_d.column_found = head_i.col;
            result_d.cell_value   = '0;
            result_d.cell_valid   = 1'b0;
          end else begin
            state_d = BK_EXEC;
          end
        end
      end
      BK_EXEC: begin
        state_d               = BK_IDLE;
        done_d                = 1'b1;
        result_d.hit          = job_q.hit;
        result_d.row_found    = job_q.row;
        result_d.column_found = job_q.col;
        result_d.cell_value   = '0;
        result_d.cell_valid   = 1'b0;
        case (job_q.op)
          OP_PEAK, OP_AVG: begin
            mem_we              = 1'b1;
            fill_set            = 1'b1;
            result_d.cell_value = new_val;
            result_d.cell_valid = 1'b1;
          end
          OP_CLEAR: begin
            fill_clr = 1'b1;
          end
          OP_READ: begin
            if (old_ok) begin
              result_d.cell_value = rd_q;
              result_d.cell_valid = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[ex_addr] <= new_val;
    end
    rd_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      done_q   <= 1'b0;
      filled_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (fill_set) begin
        filled_q[ex_addr] <= 1'b1;
      end
      if (fill_clr) begin
        filled_q[ex_addr] <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BK_IDLE)) else $error("job taken while busy");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC) |=> (state_q == BK_IDLE && done_q))
    else $error("cell job did not finish in one cycle");
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(pop_o || state_q == BK_EXEC))
    else $error("result beat without a job");
`endif

endmodule

// ----- rtl/engine_map_cell_logger.sv -----
// Top level of the engine map cell logger: config register, front, queue and back.
// A load, miss or pass command goes through the staging register, the job queue and
// the result register; a record, clear or read also passes the back end's exec state
// after the registered cell read. The front's single staging register takes a new
// item only once the staged one is pushed (capture, then push) into the queue.
// Results cannot stall. Reset: breakpoints load their default tables, every cell is empty.
module engine_map_cell_logger import emcl_pkg::*; #(
  parameter int unsigned ROWS    = 11,
  parameter int unsigned COLUMNS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  logic single_row_q;
  logic push, pop, full, empty;
  job_t job, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_row_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      single_row_q <= cfg_data_i;
    end
  end

  emcl_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .item_i       (item_i),
    .single_row_i (single_row_q),
    .full_i       (full),
    .busy_o       (busy),
    .push_o       (push),
    .job_o        (job)
  );

  emcl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  emcl_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the engine map cell logger: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import emcl_pkg::*;

  localparam int ROWS          = 11;
  localparam int COLUMNS       = 16;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int PHASE_ITEMS   = 470;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int KEEP_MODE     = -1;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [7:0] ROW_DEFAULT [ROWS] = '{
    8'd0, 8'd4, 8'd8, 8'd15, 8'd20, 8'd27, 8'd35, 8'd50, 8'd70, 8'd85, 8'd100
  };
  localparam logic [7:0] COL_DEFAULT [COLUMNS] = '{
    8'd0, 8'd20, 8'd40, 8'd55, 8'd70, 8'd80, 8'd90, 8'd100,
    8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 8'd160, 8'd165, 8'd180
  };
  localparam logic [15:0] EDGE_SAMPLES [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  typedef struct {
    int   mode_sel;
    in_t  stim;
    bit   typed;
    out_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic done_o;
  out_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  // shadow of the map state
  logic [7:0]              row_brk   [ROWS];
  logic [7:0]              col_brk   [COLUMNS];
  logic signed [VAL_W-1:0] cell_val  [CELLS];
  bit                      cell_full [CELLS];
  bit                      cell_seen [CELLS];
  int                      written_cells [$];
  bit                      single_row_q;

  out_t      expected_q [$];
  plan_row_t plan [$];
  bit        item_typed;
  out_t      item_want;
  int        mismatch_count;
  int        quiet_cycles;
  bit        no_idle;

  engine_map_cell_logger #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int row_of(input logic [7:0] tp);
    if (tp >= row_brk[ROWS-1]) return ROWS - 1;
    for (int i = 0; i < ROWS - 1; i++)
      if (tp >= row_brk[i] && tp <= row_brk[i+1]) return i;
    return -1;
  endfunction

  function automatic int col_of(input logic [15:0] rpm);
    if (int'(rpm) >= int'(col_brk[COLUMNS-1]) * 100) return COLUMNS - 1;
    for (int i = 0; i < COLUMNS - 1; i++)
      if (int'(rpm) >= int'(col_brk[i]) * 100 && int'(rpm) <= int'(col_brk[i+1]) * 100)
        return i;
    return -1;
  endfunction

  // applies one command to the shadow map and returns the result it should produce
  function automatic out_t log_cell_op(input in_t it);
    out_t res;
    int r, c, idx, total;
    logic signed [VAL_W-1:0] cur;
    res = '0;
    case (it.command)
      CMD_LOAD_ROW, CMD_LOAD_COL: begin
        res.row_found = it.row_index;
        res.column_found = it.column_index;
        if (it.command == CMD_LOAD_ROW && int'(it.row_index) < ROWS) begin
          res.hit = 1'b1;
          if (!single_row_q) row_brk[it.row_index] = it.breakpoint;
        end else if (it.command == CMD_LOAD_COL && int'(it.column_index) < COLUMNS) begin
          res.hit = 1'b1;
          col_brk[it.column_index] = it.breakpoint;
        end
      end
      CMD_PEAK, CMD_AVG: begin
        r = single_row_q ? 0 : row_of(it.throttle);
        c = col_of(it.engine_speed);
        if (r >= 0 && c >= 0) begin
          idx = r * COLUMNS + c;
          cur = it.sample;
          if (cell_full[idx]) begin
            if (it.command == CMD_PEAK) begin
              cur = (cell_val[idx] > it.sample) ? cell_val[idx] : it.sample;
            end else begin
              // int sum, arithmetic shift rounds toward minus infinity
              total = int'(cell_val[idx]) + int'(it.sample);
              cur = VAL_W'(total >>> 1);
            end
          end
          cell_val[idx] = cur;
          cell_full[idx] = 1'b1;
          if (!cell_seen[idx]) begin
            cell_seen[idx] = 1'b1;
            written_cells.push_back(idx);
          end
          res.hit = 1'b1;
          res.row_found = IDX_W'(r);
          res.column_found = IDX_W'(c);
          res.cell_value = cur;
          res.cell_valid = 1'b1;
        end
      end
      CMD_CLEAR, CMD_READ: begin
        res.row_found = it.row_index;
        res.column_found = it.column_index;
        if (int'(it.row_index) < ROWS && int'(it.column_index) < COLUMNS) begin
          idx = int'(it.row_index) * COLUMNS + int'(it.column_index);
          res.hit = 1'b1;
          if (it.command == CMD_CLEAR) begin
            cell_full[idx] = 1'b0;
          end else if (cell_full[idx]) begin
            res.cell_value = cell_val[idx];
            res.cell_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // predictor and result check, both on the rising edge
  always @(posedge clk_i) begin
    out_t want;
    out_t model;
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) row_brk[i] = ROW_DEFAULT[i];
      for (int i = 0; i < COLUMNS; i++) col_brk[i] = COL_DEFAULT[i];
      for (int i = 0; i < CELLS; i++) begin
        cell_val[i] = '0;
        cell_full[i] = 1'b0;
      end
      single_row_q = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) single_row_q = cfg_data_i;
      if (start && !busy) begin
        model = log_cell_op(item_i);
        expected_q.push_back(item_typed ? item_want : model);
      end
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (result_o.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, result_o.hit);
            mismatch_count++;
          end
          if (result_o.row_found !== want.row_found) begin
            $error("row_found: expected %0d, got %0d", want.row_found, result_o.row_found);
            mismatch_count++;
          end
          if (result_o.column_found !== want.column_found) begin
            $error("column_found: expected %0d, got %0d",
                   want.column_found, result_o.column_found);
            mismatch_count++;
          end
          if (result_o.cell_value !== want.cell_value) begin
            $error("cell_value: expected %0d, got %0d", want.cell_value, result_o.cell_value);
            mismatch_count++;
          end
          if (result_o.cell_valid !== want.cell_valid) begin
            $error("cell_valid: expected %0d, got %0d", want.cell_valid, result_o.cell_valid);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ends the run when nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t cmd_item(input logic [2:0] cmd, input logic [7:0] tp,
                                   input logic [15:0] rpm, input logic [15:0] smp,
                                   input logic [3:0] ri, input logic [3:0] ci,
                                   input logic [7:0] brk);
    in_t it;
    it.command = cmd;
    it.throttle = tp;
    it.engine_speed = rpm;
    it.sample = smp;
    it.row_index = ri;
    it.column_index = ci;
    it.breakpoint = brk;
    return it;
  endfunction

  function automatic out_t cell_res(input logic hit, input logic [3:0] r, input logic [3:0] c,
                                    input logic [15:0] v, input logic valid);
    out_t res;
    res.hit = hit;
    res.row_found = r;
    res.column_found = c;
    res.cell_value = v;
    res.cell_valid = valid;
    return res;
  endfunction

  function automatic void plan_row(input int mode_sel, input in_t stim, input bit typed,
                                   input out_t want);
    plan.push_back('{mode_sel, stim, typed, want});
  endfunction

  // called at a falling edge; returns at a falling edge after the beat is taken
  task automatic send_cmd(input in_t it, input bit typed, input out_t want);
    int gap;
    int pick;
    item_typed = typed;
    item_want = want;
    item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_defaults(input bit rows_too);
    if (rows_too)
      for (int i = 0; i < ROWS; i++)
        send_cmd(cmd_item(CMD_LOAD_ROW, 8'($urandom), 16'($urandom), 16'($urandom), 4'(i),
                          4'($urandom), ROW_DEFAULT[i]), 1'b0, '0);
    for (int i = 0; i < COLUMNS; i++)
      send_cmd(cmd_item(CMD_LOAD_COL, 8'($urandom), 16'($urandom), 16'($urandom),
                        4'($urandom), 4'(i), COL_DEFAULT[i]), 1'b0, '0);
  endtask

  initial begin
    in_t        it;
    logic [2:0] op;
    int         pick;
    int         counted;
    int         total;
    int         cell_pick;
    bit         mode;

    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    item_typed = 1'b0;
    item_want = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;

    // directed: default breakpoints, single-row mode off
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 0, 0, 16'h7FFF, 0, 0, 0), 1,
             cell_res(1, 0, 0, 16'h7FFF, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 0, 0, 16'h8000, 0, 0, 0), 1,
             cell_res(1, 0, 0, 16'h7FFF, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_AVG, 0, 0, 16'h8000, 0, 0, 0), 1,
             cell_res(1, 0, 0, 16'hFFFF, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_AVG, 0, 0, 16'h0002, 0, 0, 0), 1,
             cell_res(1, 0, 0, 16'h0000, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0, 8'hFF), 1,
             cell_res(1, 0, 0, 16'h0000, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, cell_res(1, 0, 0, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0), 1, cell_res(1, 0, 0, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 255, 16'hFFFF, 16'h8000, 0, 0, 0), 1,
             cell_res(1, 10, 15, 16'h8000, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 100, 18000, 16'h0100, 0, 0, 0), 1,
             cell_res(1, 10, 15, 16'h0100, 1));
    // both keys sit exactly on the upper bound of the first interval
    plan_row(KEEP_MODE, cmd_item(CMD_AVG, 4, 2000, 16'h1234, 0, 0, 0), 1,
             cell_res(1, 0, 0, 16'h1234, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_READ, 0, 0, 0, 11, 0, 0), 1, cell_res(0, 11, 0, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_READ, 0, 0, 0, 15, 15, 0), 1, cell_res(0, 15, 15, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_CLEAR, 0, 0, 0, 10, 15, 0), 1,
             cell_res(1, 10, 15, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_LOAD_ROW, 0, 0, 0, 0, 3, 10), 1, cell_res(1, 0, 3, 0, 0));
    // throttle now below the first row breakpoint
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 3, 0, 16'h5555, 0, 0, 0), 1, cell_res(0, 0, 0, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_LOAD_ROW, 0, 0, 0, 11, 5, 7), 1, cell_res(0, 11, 5, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_LOAD_COL, 0, 0, 0, 4, 15, 255), 1,
             cell_res(1, 4, 15, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 200, 16'hFFFF, 16'h7FFF, 0, 0, 0), 1,
             cell_res(1, 10, 15, 16'h7FFF, 1));
    plan_row(KEEP_MODE, cmd_item(CMD_LOAD_COL, 0, 0, 0, 0, 0, 255), 1, cell_res(1, 0, 0, 0, 0));
    // column table no longer sorted, low rpm finds no interval
    plan_row(KEEP_MODE, cmd_item(CMD_AVG, 50, 1000, 16'h2222, 0, 0, 0), 1,
             cell_res(0, 0, 0, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_SPARE_6, 8'hFF, 16'hFFFF, 16'hFFFF, 15, 15, 8'hFF), 1,
             '0);
    plan_row(KEEP_MODE, cmd_item(CMD_SPARE_7, 8'hAA, 16'h5555, 16'hAAAA, 5, 10, 8'h55), 1,
             '0);
    plan_row(KEEP_MODE, cmd_item(CMD_LOAD_ROW, 0, 0, 0, 10, 0, 0), 1, cell_res(1, 10, 0, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 5, 3000, 16'h0042, 0, 0, 0), 0, '0);
    // single-row mode: row loads are dropped but still report the index check
    plan_row(1, cmd_item(CMD_LOAD_ROW, 0, 0, 0, 2, 1, 99), 1, cell_res(1, 2, 1, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_AVG, 255, 16'hFFFF, 16'hFFFE, 0, 0, 0), 0, '0);
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 3, 3000, 16'h0100, 0, 0, 0), 0, '0);
    plan_row(0, cmd_item(CMD_LOAD_ROW, 0, 0, 0, 15, 15, 255), 1, cell_res(0, 15, 15, 0, 0));
    plan_row(KEEP_MODE, cmd_item(CMD_PEAK, 50, 16'hFFFF, 16'h1000, 0, 0, 0), 0, '0);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].mode_sel != KEEP_MODE) write_mode(plan[k].mode_sel[0]);
      send_cmd(plan[k].stim, plan[k].typed, plan[k].want);
    end

    total = 0;
    for (int ph = 0; ph < 4; ph++) begin
      mode = (ph % 2 == 0);
      write_mode(mode);
      load_defaults(!mode);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = CMD_PEAK;
        else if (pick < 74) op = CMD_AVG;
        else if (pick < 86) op = CMD_READ;
        else if (pick < 92) op = CMD_CLEAR;
        else if (pick < 95) op = CMD_LOAD_ROW;
        else if (pick < 98) op = CMD_LOAD_COL;
        else if (pick == 98) op = CMD_SPARE_6;
        else op = CMD_SPARE_7;
        it.command = op;
        it.throttle = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 110)) : 8'($urandom);
        it.engine_speed = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 19000))
                                                      : 16'($urandom);
        it.sample = ($urandom_range(0, 9) == 0) ? EDGE_SAMPLES[$urandom_range(0, 3)]
                                                : 16'($urandom);
        it.row_index = 4'($urandom);
        it.column_index = 4'($urandom);
        it.breakpoint = 8'($urandom);
        if (op == CMD_READ || op == CMD_CLEAR) begin
          // stay on cells that have held data; otherwise aim past the last row
          if (written_cells.size() != 0 && $urandom_range(0, 6) != 0) begin
            cell_pick = written_cells[$urandom_range(0, written_cells.size() - 1)];
            it.row_index = 4'(cell_pick / COLUMNS);
            it.column_index = 4'(cell_pick % COLUMNS);
          end else begin
            it.row_index = 4'($urandom_range(ROWS, 15));
          end
        end else if (op == CMD_LOAD_ROW && int'(it.row_index) < ROWS && $urandom_range(0, 1)) begin
          it.breakpoint = ROW_DEFAULT[it.row_index] + 8'($urandom_range(0, 3));
        end else if (op == CMD_LOAD_COL && $urandom_range(0, 1)) begin
          it.breakpoint = COL_DEFAULT[it.column_index] + 8'($urandom_range(0, 3));
        end
        send_cmd(it, 1'b0, '0);
        if (op != CMD_SPARE_6 && op != CMD_SPARE_7) begin
          counted++;
          total++;
          if (total % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
          if (total % 300 == 0) quiesce();
        end
      end
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
